FILE: rtl/tce_pkg.sv
package tce_pkg;

  localparam int COLS_DEF     = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int MEM_AW = 13;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-3:0] REG_TEXT_ATTR = 1'b0;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_CLS   = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_CLROW = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_UNMAPPED = 8'h3F;

  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET = 16'h0720;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [4:0]  row_now;
    logic [6:0]  col_now;
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } res_t;

  // Latin-1 to CP437; bytes without a glyph show as a question mark.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] g;
    if (!c[7]) begin
      g = c;
    end else begin
      unique case (c)
        8'hA3: g = 8'h9C;
        8'hA7: g = 8'h15;
        8'hB0: g = 8'hF8;
        8'hC0: g = 8'h41;
        8'hC7: g = 8'h80;
        8'hC8: g = 8'h45;
        8'hC9: g = 8'h90;
        8'hCC: g = 8'h49;
        8'hD2: g = 8'h4F;
        8'hD9: g = 8'h55;
        8'hE0: g = 8'h85;
        8'hE1: g = 8'hA0;
        8'hE2: g = 8'h83;
        8'hE4: g = 8'h84;
        8'hE5: g = 8'h86;
        8'hE6: g = 8'h91;
        8'hE7: g = 8'h87;
        8'hE8: g = 8'h8A;
        8'hE9: g = 8'h82;
        8'hEA: g = 8'h88;
        8'hEB: g = 8'h89;
        8'hEC: g = 8'h8D;
        8'hED: g = 8'hA1;
        8'hEE: g = 8'h8C;
        8'hEF: g = 8'h8B;
        8'hF1: g = 8'hA4;
        8'hF2: g = 8'h95;
        8'hF3: g = 8'hA2;
        8'hF4: g = 8'h93;
        8'hF6: g = 8'h94;
        8'hF9: g = 8'h97;
        8'hFA: g = 8'hA3;
        8'hFB: g = 8'h96;
        8'hFC: g = 8'h81;
        default: g = CH_UNMAPPED;
      endcase
    end
    return g;
  endfunction

endpackage

FILE: rtl/text_console_engine_unit.sv
// Channel   Direction  Handshake            Payload
// in_*      input      in_valid / in_stall  cmd, char_code, row, col, fg, bg
// out_*     output     out_valid / out_stall cursor_row_out, cursor_col_out, cursor_pos,
//                                           cell_data
// APB       input      psel/penable/pready  text_attr at byte address 0
//
// Put char, move, write at and unused commands pass through S_EXEC and S_DONE; read cell adds S_RDWAIT between them.
// Clear screen and clear row fill the whole screen or one row in S_FILL, one cell write per cycle.
// A put char that scrolls adds S_COPY, S_DRAIN and S_FILL for the row copy and blank fill.
// After reset the cell memory is filled with blanks before in_stall drops.
// The result register lets the next transfer start while a result is stalled.
module text_console_engine_unit #(
  parameter int COLS     = tce_pkg::COLS_DEF,
  parameter int ROWS     = tce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tce_pkg::TAB_STEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_cmd,
  input  logic [7:0]                  in_char_code,
  input  logic [7:0]                  in_row,
  input  logic [7:0]                  in_col,
  input  logic [3:0]                  in_fg,
  input  logic [3:0]                  in_bg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  out_cursor_row_out,
  output logic [6:0]                  out_cursor_col_out,
  output logic [10:0]                 out_cursor_pos,
  output logic [15:0]                 out_cell_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tce_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tce_pkg::*;

  logic [7:0] attr_r;
  logic       out_valid_r;
  res_t       res_r;
  res_t       res;
  logic       res_valid;
  logic       seq_idle;
  logic       out_free;
  logic       attr_sel;
  mem_req_t   mem_req;
  logic [15:0] rd_data;

  assign pready   = 1'b1;
  assign attr_sel = (paddr[CFG_AW-1:2] == REG_TEXT_ATTR);
  assign prdata   = attr_sel ? {24'b0, attr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && attr_sel) begin
      attr_r <= pwdata[7:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !seq_idle;

  tce_seq #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && seq_idle),
    .cmd       (in_cmd),
    .char_code (in_char_code),
    .row       (in_row),
    .col       (in_col),
    .fg        (in_fg),
    .bg        (in_bg),
    .text_attr (attr_r),
    .out_free  (out_free),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  tce_cell_ram #(
    .DEPTH (ROWS * COLS)
  ) u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_row_out = res_r.row_now;
  assign out_cursor_col_out = res_r.col_now;
  assign out_cursor_pos     = res_r.cursor_pos;
  assign out_cell_data      = res_r.cell_data;

endmodule

FILE: rtl/tce_cell_ram.sv
module tce_cell_ram #(
  parameter int DEPTH = tce_pkg::ROWS_DEF * tce_pkg::COLS_DEF
) (
  input  logic              clk,
  input  tce_pkg::mem_req_t req,
  output logic [15:0]       rd_data
);
  import tce_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/tce_seq.sv
module tce_seq #(
  parameter int COLS     = tce_pkg::COLS_DEF,
  parameter int ROWS     = tce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tce_pkg::TAB_STEP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic [7:0]        row,
  input  logic [7:0]        col,
  input  logic [3:0]        fg,
  input  logic [3:0]        bg,
  input  logic [7:0]        text_attr,
  input  logic              out_free,
  output logic              idle,
  output logic              res_valid,
  output tce_pkg::res_t     res,
  output tce_pkg::mem_req_t mem_req,
  input  logic [15:0]       rd_data
);
  import tce_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_COPY   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [15:0]   fill_val_r, fill_val_nxt;
  logic          fill_rep_r, fill_rep_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [15:0]   data_r, data_nxt;

  logic [CW-1:0] tab_col [2**CW];
  logic          tab_wrap [2**CW];

  logic [RW-1:0] addr_row;
  logic [CW-1:0] addr_col;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] pos;
  logic [RW:0]   nrow;
  logic [CW-1:0] ncol;
  logic          row_ok;
  logic          col_ok;

  for (genvar gi = 0; gi < 2**CW; gi++) begin : g_tab
    localparam int NEXT = (gi / TAB_STEP + 1) * TAB_STEP;
    assign tab_wrap[gi] = (NEXT >= COLS);
    assign tab_col[gi]  = (NEXT >= COLS) ? '0 : CW'(NEXT);
  end

  assign row_ok = (row_r < 8'(ROWS));
  assign col_ok = (col_r < 8'(COLS));

  always_comb begin
    if (cmd_r == CMD_PUT) begin
      addr_row = cur_row_r;
      addr_col = (ch_r == CH_BS) ? cur_col_r - 1'b1 : cur_col_r;
    end else begin
      addr_row = row_r[RW-1:0];
      addr_col = (cmd_r == CMD_CLROW) ? '0 : col_r[CW-1:0];
    end
  end

  assign cell_addr = AW'(addr_row) * AW'(COLS) + AW'(addr_col);
  assign pos       = AW'(cur_row_r) * AW'(COLS) + AW'(cur_col_r);

  assign idle           = (state_r == S_IDLE);
  assign res.row_now    = 5'(cur_row_r);
  assign res.col_now    = 7'(cur_col_r);
  assign res.cursor_pos = 11'(pos);
  assign res.cell_data  = data_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    ch_nxt       = ch_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    attr_nxt     = attr_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    ptr_nxt      = ptr_r;
    end_nxt      = end_r;
    fill_val_nxt = fill_val_r;
    fill_rep_nxt = fill_rep_r;
    pend_nxt     = pend_r;
    waddr_nxt    = waddr_r;
    data_nxt     = data_r;
    mem_req      = '0;
    res_valid    = 1'b0;
    nrow         = {1'b0, cur_row_r};
    ncol         = cur_col_r;

    if (pend_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = MEM_AW'(waddr_r);
      mem_req.wdata = rd_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          ch_nxt    = char_code;
          row_nxt   = row;
          col_nxt   = col;
          attr_nxt  = {bg, fg};
          data_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_PUT: begin
            unique case (ch_r)
              CH_LF: begin
                ncol = '0;
                nrow = nrow + 1'b1;
              end
              CH_CR: begin
                ncol = '0;
              end
              CH_TAB: begin
                ncol = tab_col[cur_col_r];
                if (tab_wrap[cur_col_r]) begin
                  nrow = nrow + 1'b1;
                end
              end
              CH_BS: begin
                if (cur_col_r != '0) begin
                  ncol          = cur_col_r - 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.waddr = MEM_AW'(cell_addr);
                  mem_req.wdata = {text_attr, CH_SPACE};
                end
              end
              default: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(cell_addr);
                mem_req.wdata = {text_attr, glyph_of(ch_r)};
                if (cur_col_r == CW'(COLS - 1)) begin
                  ncol = '0;
                  nrow = nrow + 1'b1;
                end else begin
                  ncol = cur_col_r + 1'b1;
                end
              end
            endcase
            cur_col_nxt = ncol;
            if (nrow >= (RW+1)'(ROWS)) begin
              cur_row_nxt = RW'(ROWS - 1);
              ptr_nxt     = AW'(COLS);
              state_nxt   = S_COPY;
            end else begin
              cur_row_nxt = nrow[RW-1:0];
            end
          end
          CMD_MOVE: begin
            cur_row_nxt = row_ok ? row_r[RW-1:0] : RW'(ROWS - 1);
            cur_col_nxt = col_ok ? col_r[CW-1:0] : CW'(COLS - 1);
          end
          CMD_CLS: begin
            cur_row_nxt  = '0;
            cur_col_nxt  = '0;
            ptr_nxt      = '0;
            end_nxt      = AW'(NCELLS - 1);
            fill_val_nxt = {text_attr, CH_SPACE};
            fill_rep_nxt = 1'b1;
            state_nxt    = S_FILL;
          end
          CMD_WRITE: begin
            if (row_ok && col_ok) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = MEM_AW'(cell_addr);
              mem_req.wdata = {attr_r, glyph_of(ch_r)};
            end
          end
          CMD_CLROW: begin
            if (row_ok) begin
              ptr_nxt      = cell_addr;
              end_nxt      = cell_addr + AW'(COLS - 1);
              fill_val_nxt = {attr_r, CH_SPACE};
              fill_rep_nxt = 1'b1;
              state_nxt    = S_FILL;
            end
          end
          CMD_READ: begin
            if (row_ok && col_ok) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = MEM_AW'(cell_addr);
              state_nxt     = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        data_nxt  = rd_data;
        state_nxt = S_DONE;
      end

      S_COPY: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = MEM_AW'(ptr_r);
        pend_nxt      = 1'b1;
        waddr_nxt     = ptr_r - AW'(COLS);
        ptr_nxt       = ptr_r + 1'b1;
        if (ptr_r == AW'(NCELLS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        pend_nxt     = 1'b0;
        ptr_nxt      = AW'(NCELLS - COLS);
        end_nxt      = AW'(NCELLS - 1);
        fill_val_nxt = {text_attr, CH_SPACE};
        fill_rep_nxt = 1'b1;
        state_nxt    = S_FILL;
      end

      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_AW'(ptr_r);
        mem_req.wdata = fill_val_r;
        ptr_nxt       = ptr_r + 1'b1;
        if (ptr_r == end_r) begin
          state_nxt = fill_rep_r ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      ptr_r      <= '0;
      end_r      <= AW'(NCELLS - 1);
      fill_val_r <= CELL_RESET;
      fill_rep_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      ptr_r      <= ptr_nxt;
      end_r      <= end_nxt;
      fill_val_r <= fill_val_nxt;
      fill_rep_r <= fill_rep_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    ch_r    <= ch_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    attr_r  <= attr_nxt;
    waddr_r <= waddr_nxt;
    data_r  <= data_nxt;
  end

endmodule

FILE: tb/console_screen_checker.sv
`timescale 1ns / 1ps
module console_screen_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [2:0]                  in_cmd,
  input  logic [7:0]                  in_char_code,
  input  logic [7:0]                  in_row,
  input  logic [7:0]                  in_col,
  input  logic [3:0]                  in_fg,
  input  logic [3:0]                  in_bg,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [4:0]                  out_cursor_row_out,
  input  logic [6:0]                  out_cursor_col_out,
  input  logic [10:0]                 out_cursor_pos,
  input  logic [15:0]                 out_cell_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tce_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          n_fail,
  output int                          n_pending
);
  import tce_pkg::*;

  localparam int NCOL  = COLS_DEF;
  localparam int NROW  = ROWS_DEF;
  localparam int TABW  = TAB_STEP_DEF;
  localparam int NCELL = NROW * NCOL;
  localparam int NMAP  = 34;
  localparam logic [CFG_AW-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  localparam logic [NMAP*8-1:0] LATIN1_KEYS = {
    8'hA3, 8'hA7, 8'hB0, 8'hC0, 8'hC7, 8'hC8, 8'hC9, 8'hCC, 8'hD2, 8'hD9,
    8'hE0, 8'hE1, 8'hE2, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA,
    8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF6,
    8'hF9, 8'hFA, 8'hFB, 8'hFC
  };
  localparam logic [NMAP*8-1:0] CP437_GLYPHS = {
    8'h9C, 8'h15, 8'hF8, 8'h41, 8'h80, 8'h45, 8'h90, 8'h49, 8'h4F, 8'h55,
    8'h85, 8'hA0, 8'h83, 8'h84, 8'h86, 8'h91, 8'h87, 8'h8A, 8'h82, 8'h88,
    8'h89, 8'h8D, 8'hA1, 8'h8C, 8'h8B, 8'hA4, 8'h95, 8'hA2, 8'h93, 8'h94,
    8'h97, 8'hA3, 8'h96, 8'h81
  };

  logic [15:0]  screen [NCELL];
  int unsigned  crow;
  int unsigned  ccol;
  logic [7:0]   text_attr;
  res_t         cursor_cell_due [$];
  res_t         want;
  res_t         got;
  int           fails;

  function automatic logic [7:0] cp437_of(input logic [7:0] code);
    logic [7:0] g;
    g = CH_UNMAPPED;
    if (!code[7]) begin
      g = code;
    end else begin
      for (int i = 0; i < NMAP; i++) begin
        if (LATIN1_KEYS[(NMAP-1-i)*8 +: 8] == code) begin
          g = CP437_GLYPHS[(NMAP-1-i)*8 +: 8];
        end
      end
    end
    return g;
  endfunction

  function automatic res_t run_console_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                                            input logic [7:0] r, input logic [7:0] c,
                                            input logic [3:0] fg, input logic [3:0] bg);
    res_t        res;
    logic [15:0] data;
    int          pos;
    data = 16'h0000;
    case (cmd)
      CMD_PUT: begin
        case (ch)
          CH_LF: begin
            ccol = 0;
            crow++;
          end
          CH_CR: begin
            ccol = 0;
          end
          CH_TAB: begin
            ccol = (ccol / TABW + 1) * TABW;
            if (ccol >= NCOL) begin
              ccol = 0;
              crow++;
            end
          end
          CH_BS: begin
            if (ccol > 0) begin
              ccol--;
              screen[crow*NCOL + ccol] = {text_attr, CH_SPACE};
            end
          end
          default: begin
            screen[crow*NCOL + ccol] = {text_attr, cp437_of(ch)};
            ccol++;
            if (ccol >= NCOL) begin
              ccol = 0;
              crow++;
            end
          end
        endcase
        if (crow >= NROW) begin
          for (int i = 0; i < NCELL - NCOL; i++) screen[i] = screen[i + NCOL];
          for (int i = NCELL - NCOL; i < NCELL; i++) screen[i] = {text_attr, CH_SPACE};
          crow = NROW - 1;
        end
      end
      CMD_MOVE: begin
        crow = (r < NROW) ? r : NROW - 1;
        ccol = (c < NCOL) ? c : NCOL - 1;
      end
      CMD_CLS: begin
        for (int i = 0; i < NCELL; i++) screen[i] = {text_attr, CH_SPACE};
        crow = 0;
        ccol = 0;
      end
      CMD_WRITE: begin
        if (r < NROW && c < NCOL) screen[r*NCOL + c] = {bg, fg, cp437_of(ch)};
      end
      CMD_CLROW: begin
        if (r < NROW) begin
          for (int i = 0; i < NCOL; i++) screen[r*NCOL + i] = {bg, fg, CH_SPACE};
        end
      end
      CMD_READ: begin
        if (r < NROW && c < NCOL) data = screen[r*NCOL + c];
      end
      default: begin
      end
    endcase
    pos = crow * NCOL + ccol;
    res.row_now    = crow[4:0];
    res.col_now    = ccol[6:0];
    res.cursor_pos = pos[10:0];
    res.cell_data  = data;
    return res;
  endfunction

  function automatic void note_field(input string name, input logic [15:0] want_v,
                                     input logic [15:0] got_v);
    if (want_v !== got_v) begin
      if (fails < 10) begin
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, want_v, got_v);
      end
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCELL; i++) screen[i] = CELL_RESET;
      crow = 0;
      ccol = 0;
      text_attr = ATTR_RESET;
      cursor_cell_due.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
        text_attr = pwdata[7:0];
      end
      if (out_valid && !out_stall) begin
        got.row_now    = out_cursor_row_out;
        got.col_now    = out_cursor_col_out;
        got.cursor_pos = out_cursor_pos;
        got.cell_data  = out_cell_data;
        if (cursor_cell_due.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result transfer with nothing pending: row %0d col %0d pos %0d cell %h",
                     $realtime, got.row_now, got.col_now, got.cursor_pos, got.cell_data);
          end
          fails++;
        end else begin
          want = cursor_cell_due.pop_front();
          note_field("cursor_row_out", 16'(want.row_now), 16'(got.row_now));
          note_field("cursor_col_out", 16'(want.col_now), 16'(got.col_now));
          note_field("cursor_pos", 16'(want.cursor_pos), 16'(got.cursor_pos));
          note_field("cell_data", want.cell_data, got.cell_data);
        end
      end
      if (in_valid && !in_stall) begin
        cursor_cell_due.push_back(run_console_cmd(in_cmd, in_char_code, in_row, in_col,
                                                  in_fg, in_bg));
      end
    end
    n_pending <= cursor_cell_due.size();
    n_fail <= fails;
  end

endmodule

FILE: tb/text_console_engine_unit_tb.sv
`timescale 1ns / 1ps
module text_console_engine_unit_tb;
  import tce_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [CFG_AW-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};
  localparam int LONG_HOLD  = 400;
  localparam int HOLD_AFTER = 60;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_cmd;
  logic [7:0]         in_char_code;
  logic [7:0]         in_row;
  logic [7:0]         in_col;
  logic [3:0]         in_fg;
  logic [3:0]         in_bg;
  logic               out_valid;
  logic               out_stall;
  logic [4:0]         out_cursor_row_out;
  logic [6:0]         out_cursor_col_out;
  logic [10:0]        out_cursor_pos;
  logic [15:0]        out_cell_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int n_fail;
  int n_pending;
  int n_sent;
  int n_taken;
  int rx_burst;
  bit idle_on;
  bit long_done;

  text_console_engine_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_row             (in_row),
    .in_col             (in_col),
    .in_fg              (in_fg),
    .in_bg              (in_bg),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_pos     (out_cursor_pos),
    .out_cell_data      (out_cell_data),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  console_screen_checker screen_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_row             (in_row),
    .in_col             (in_col),
    .in_fg              (in_fg),
    .in_bg              (in_bg),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_pos     (out_cursor_pos),
    .out_cell_data      (out_cell_data),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .n_fail             (n_fail),
    .n_pending          (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver stalls in short random bursts, and once holds off long
  // enough for the block to back up and stall its input.
  initial begin
    out_stall <= 1'b0;
    n_taken = 0;
    rx_burst = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) n_taken++;
      if (!idle_on) begin
        rx_burst = 0;
        out_stall <= 1'b0;
      end else if (!long_done && n_taken >= HOLD_AFTER) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_burst > 0) begin
        rx_burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic issue_console_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                                   input logic [7:0] r, input logic [7:0] c,
                                   input logic [3:0] fg, input logic [3:0] bg);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_char_code <= ch;
    in_row       <= r;
    in_col       <= c;
    in_fg        <= fg;
    in_bg        <= bg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic write_text_attr(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_console();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 8'($urandom_range(8'h20, 8'h7E));
    else if (p < 80) return 8'($urandom_range(8'h80, 8'hFF));
    else if (p < 88) return CH_LF;
    else if (p < 92) return CH_CR;
    else if (p < 96) return CH_TAB;
    else return CH_BS;
  endfunction

  // Half the bursts are lines of text typed at the cursor, often near the bottom
  // or the right edge; the rest are commands, some out of range, or raw noise.
  task automatic random_burst();
    int         kind;
    int         pick;
    int         n;
    logic [7:0] r;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 9) < 4) r = 8'(ROWS_DEF - 1);
        else r = 8'($urandom_range(0, ROWS_DEF - 1));
        if ($urandom_range(0, 1) == 1) c = 8'($urandom_range(0, COLS_DEF - 1));
        else c = 8'($urandom_range(COLS_DEF - 10, COLS_DEF - 1));
        issue_console_cmd(CMD_MOVE, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
      n = $urandom_range(3, 14);
      repeat (n) begin
        issue_console_cmd(CMD_PUT, pick_text_byte(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
      end
    end else if (kind < 85) begin
      pick = $urandom_range(0, 99);
      r = 8'($urandom_range(0, ROWS_DEF - 1));
      c = 8'($urandom_range(0, COLS_DEF - 1));
      if (pick < 25) begin
        issue_console_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        issue_console_cmd(CMD_READ, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 45) begin
        issue_console_cmd(CMD_READ, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 60) begin
        issue_console_cmd(CMD_MOVE, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 72) begin
        issue_console_cmd(CMD_CLROW, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 74) begin
        issue_console_cmd(CMD_CLS, 8'($urandom_range(0, 255)), r, c,
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 87) begin
        issue_console_cmd(CMD_MOVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
      end else begin
        issue_console_cmd(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
      end
    end else begin
      issue_console_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = n_sent + count;
    while (n_sent < target) random_burst();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_PUT;
    in_char_code <= 8'h00;
    in_row       <= 8'h00;
    in_col       <= 8'h00;
    in_fg        <= 4'h0;
    in_bg        <= 4'h0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= 32'h00000000;
    idle_on = 1'b1;
    n_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    issue_console_cmd(CMD_READ, 8'h00, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_READ, 8'hFF, 8'd24, 8'd79, 4'hF, 4'hF);
    issue_console_cmd(CMD_PUT, 8'h41, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, 8'h00, 8'hFF, 8'hFF, 4'hF, 4'hF);
    issue_console_cmd(CMD_PUT, 8'hE8, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, 8'hFF, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_TAB, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_BS, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_CR, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_BS, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_LF, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_MOVE, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, 8'h7F, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_READ, 8'h00, 8'd23, 8'd79, 4'h0, 4'h0);
    issue_console_cmd(CMD_MOVE, 8'h00, 8'd3, 8'd78, 4'h0, 4'h0);
    issue_console_cmd(CMD_PUT, CH_TAB, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_WRITE, 8'h80, 8'd24, 8'd79, 4'hF, 4'hF);
    issue_console_cmd(CMD_WRITE, 8'h41, 8'd25, 8'd0, 4'h1, 4'h2);
    issue_console_cmd(CMD_WRITE, 8'h42, 8'd0, 8'd80, 4'h3, 4'h4);
    issue_console_cmd(CMD_READ, 8'h00, 8'd24, 8'd79, 4'h0, 4'h0);
    issue_console_cmd(CMD_CLROW, 8'h00, 8'd24, 8'd0, 4'h5, 4'hA);
    issue_console_cmd(CMD_CLROW, 8'h00, 8'd25, 8'd0, 4'hF, 4'hF);
    issue_console_cmd(CMD_READ, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0);
    issue_console_cmd(CMD_SPARE6, 8'hFF, 8'd1, 8'd1, 4'hF, 4'hF);
    issue_console_cmd(CMD_SPARE7, 8'h00, 8'd2, 8'd2, 4'h0, 4'h0);
    issue_console_cmd(CMD_CLS, 8'h00, 8'd0, 8'd0, 4'h0, 4'h0);
    issue_console_cmd(CMD_READ, 8'h00, 8'd12, 8'd40, 4'h0, 4'h0);
    drain_console();

    write_text_attr(8'h00);
    run_random(140);
    drain_console();

    write_text_attr(8'hFF);
    run_random(140);
    drain_console();

    write_text_attr(8'($urandom_range(1, 254)));
    idle_on = 1'b0;
    run_random(140);
    drain_console();

    repeat (8) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
